// ===== design/ccst_pkg.sv =====
// shared types, constants and calendar helpers of the calendar clock core
package ccst_pkg;

    // field widths
    localparam int unsigned TickW   = 8;
    localparam int unsigned IntW    = 6;
    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinW    = 6;
    localparam int unsigned SecW    = 6;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 8;
    localparam int unsigned DivCntW = 3;

    // calendar limits
    localparam logic [SecW:0]    SecPerMin  = 7'd60;
    localparam logic [MinW:0]    MinPerHour = 7'd60;
    localparam logic [HourW:0]   HourPerDay = 6'd24;
    localparam logic [MonthW:0]  MonPerYear = 5'd12;
    localparam logic [YearW:0]   YearLimit  = 15'd9999;
    localparam logic [YearW-1:0] YearReset  = 14'd2022;
    localparam logic [DayW-1:0]  DayReset   = 5'd1;
    localparam logic [MonthW-1:0] MonthReset = 4'd1;

    // register reset values
    localparam logic [TickW-1:0] TpsReset    = 8'd2;
    localparam logic [IntW-1:0]  SaveReset   = 6'd10;
    localparam logic [TickW-1:0] ScreenReset = 8'd60;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgTicksPerSec = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSaveInt     = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgScreenOn    = 2'd2;

    // remainder unit runs one bit per step over the pre-wrap minute
    localparam logic [DivCntW-1:0] DivFirstBit = 3'd6;

    // month lengths, entry 0 unused
    localparam logic [DayW-1:0] MonthLen [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_dp_stat;

    // days of the month, leap february when year mod 4 is zero
    function automatic logic [DayW-1:0] days_in_month(
        input logic [MonthW-1:0] month,
        input logic [YearW-1:0]  year
    );
        logic [DayW-1:0] len;
        if (month == 4'd0 || month > 4'd12) begin
            len = 5'd31;
        end else if (month == 4'd2 && year[1:0] == 2'b00) begin
            len = 5'd29;
        end else begin
            len = MonthLen[month];
        end
        return len;
    endfunction

endpackage

// ===== design/ccst_ctrl.sv =====
// controller state machine of the calendar clock core
module ccst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    input  ccst_pkg::t_dp_stat i_stat,
    output ccst_pkg::t_dp_cmd  o_cmd,
    output logic               o_ready,
    output logic               o_valid
);
    import ccst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.need_div ? ST_MOD : ST_HOLD;
                end
            end
            ST_MOD: begin
                if (i_stat.div_last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_MOD: begin
                o_cmd.div_step = 1'b1;
            end
            ST_HOLD: begin
                o_cmd.publish = !r_out_valid || i_ready;
            end
            default: o_cmd = '0;
        endcase
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== design/ccst_dp.sv =====
// datapath of the calendar clock core: counters, config, remainder unit, output regs
module ccst_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ccst_pkg::t_dp_cmd                i_cmd,
    output ccst_pkg::t_dp_stat               o_stat,
    input  logic                             i_cfg_we,
    input  logic [ccst_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [ccst_pkg::CfgW-1:0]        i_cfg_data,
    input  logic                             i_command,
    input  logic                             i_display_on,
    input  logic [ccst_pkg::YearW-1:0]       i_load_year,
    input  logic [ccst_pkg::MonthW-1:0]      i_load_month,
    input  logic [ccst_pkg::DayW-1:0]        i_load_day,
    input  logic [ccst_pkg::HourW-1:0]       i_load_hour,
    input  logic [ccst_pkg::MinW-1:0]        i_load_minute,
    input  logic [ccst_pkg::SecW-1:0]        i_load_second,
    output logic [ccst_pkg::YearW-1:0]       o_year_now,
    output logic [ccst_pkg::MonthW-1:0]      o_month_now,
    output logic [ccst_pkg::DayW-1:0]        o_day_now,
    output logic [ccst_pkg::HourW-1:0]       o_hour_now,
    output logic [ccst_pkg::MinW-1:0]        o_minute_now,
    output logic [ccst_pkg::SecW-1:0]        o_second_now,
    output logic                             o_minute_rolled,
    output logic                             o_save_request,
    output logic                             o_day_rolled,
    output logic                             o_screen_off,
    output logic                             o_led_level
);
    import ccst_pkg::*;

    // config registers
    logic [TickW-1:0] r_tps;
    logic [IntW-1:0]  r_save_int;
    logic [TickW-1:0] r_screen_lim;

    // time state
    logic [TickW-1:0]  r_sub;
    logic [SecW-1:0]   r_sec;
    logic [MinW-1:0]   r_min;
    logic [HourW-1:0]  r_hour;
    logic [DayW-1:0]   r_day;
    logic [MonthW-1:0] r_month;
    logic [YearW-1:0]  r_year;
    logic [TickW-1:0]  r_cd;
    logic              r_led;

    // pending flags of the beat in work
    logic r_p_min;
    logic r_p_save;
    logic r_p_day;
    logic r_p_scr;

    // remainder unit
    logic [MinW:0]      r_div_num;
    logic [IntW-1:0]    r_rem;
    logic [DivCntW-1:0] r_bit_cnt;

    // tick carry chain
    logic [TickW-1:0]  sub_inc;
    logic              sec_adv;
    logic [SecW:0]     sec_inc;
    logic              sec_wrap;
    logic [MinW:0]     min_inc;
    logic              min_wrap;
    logic [HourW:0]    hour_inc;
    logic              hour_wrap;
    logic [DayW:0]     day_inc;
    logic              day_wrap;
    logic [MonthW:0]   month_inc;
    logic              month_wrap;
    logic [YearW:0]    year_inc;
    logic              year_wrap;
    logic [TickW-1:0]  cd_inc;
    logic              scr_hit;

    logic [TickW-1:0]  n_sub;
    logic [SecW-1:0]   n_sec;
    logic [MinW-1:0]   n_min;
    logic [HourW-1:0]  n_hour;
    logic [DayW-1:0]   n_day;
    logic [MonthW-1:0] n_month;
    logic [YearW-1:0]  n_year;
    logic [TickW-1:0]  n_cd;

    always_comb begin
        sub_inc    = r_sub + 8'd1;
        sec_adv    = sub_inc >= r_tps;
        sec_inc    = {1'b0, r_sec} + 7'd1;
        sec_wrap   = sec_adv && (sec_inc >= SecPerMin);
        min_inc    = {1'b0, r_min} + 7'd1;
        min_wrap   = sec_wrap && (min_inc >= MinPerHour);
        hour_inc   = {1'b0, r_hour} + 6'd1;
        hour_wrap  = min_wrap && (hour_inc >= HourPerDay);
        day_inc    = {1'b0, r_day} + 6'd1;
        day_wrap   = hour_wrap && (day_inc > {1'b0, days_in_month(r_month, r_year)});
        month_inc  = {1'b0, r_month} + 5'd1;
        month_wrap = day_wrap && (month_inc > MonPerYear);
        year_inc   = {1'b0, r_year} + 15'd1;
        year_wrap  = month_wrap && (year_inc > YearLimit);
        cd_inc     = i_display_on ? r_cd + 8'd1 : r_cd;
        scr_hit    = cd_inc == r_screen_lim;

        n_sub   = sec_adv ? '0 : sub_inc;
        n_sec   = !sec_adv ? r_sec : (sec_wrap ? '0 : sec_inc[SecW-1:0]);
        n_min   = !sec_wrap ? r_min : (min_wrap ? '0 : min_inc[MinW-1:0]);
        n_hour  = !min_wrap ? r_hour : (hour_wrap ? '0 : hour_inc[HourW-1:0]);
        n_day   = !hour_wrap ? r_day : (day_wrap ? DayReset : day_inc[DayW-1:0]);
        n_month = !day_wrap ? r_month : (month_wrap ? MonthReset : month_inc[MonthW-1:0]);
        n_year  = !month_wrap ? r_year : (year_wrap ? '0 : year_inc[YearW-1:0]);
        n_cd    = scr_hit ? '0 : cd_inc;
    end

    // remainder step: one dividend bit a cycle
    logic [IntW:0]   rem_sh;
    logic            rem_ge;
    logic [IntW:0]   rem_diff;
    logic [IntW-1:0] rem_nx;

    always_comb begin
        rem_sh   = {r_rem, r_div_num[MinW]};
        rem_ge   = rem_sh >= {1'b0, r_save_int};
        rem_diff = rem_sh - {1'b0, r_save_int};
        rem_nx   = rem_ge ? rem_diff[IntW-1:0] : rem_sh[IntW-1:0];
    end

    // status to the controller
    assign o_stat.need_div = !i_command && sec_wrap && (r_save_int != '0);
    assign o_stat.div_last = r_bit_cnt == '0;

    // config and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TpsReset;
            r_save_int   <= SaveReset;
            r_screen_lim <= ScreenReset;
            r_sub        <= '0;
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
            r_day        <= DayReset;
            r_month      <= MonthReset;
            r_year       <= YearReset;
            r_cd         <= '0;
            r_led        <= 1'b0;
            r_bit_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgTicksPerSec: r_tps        <= i_cfg_data;
                    CfgSaveInt:     r_save_int   <= i_cfg_data[IntW-1:0];
                    CfgScreenOn:    r_screen_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_command) begin
                    r_year  <= i_load_year;
                    r_month <= i_load_month;
                    r_day   <= i_load_day;
                    r_hour  <= i_load_hour;
                    r_min   <= i_load_minute;
                    r_sec   <= i_load_second;
                end else begin
                    r_sub   <= n_sub;
                    r_sec   <= n_sec;
                    r_min   <= n_min;
                    r_hour  <= n_hour;
                    r_day   <= n_day;
                    r_month <= n_month;
                    r_year  <= n_year;
                    r_cd    <= n_cd;
                    r_led   <= ~r_led;
                end
                r_bit_cnt <= DivFirstBit;
            end else if (i_cmd.div_step) begin
                r_bit_cnt <= r_bit_cnt - 3'd1;
            end
        end
    end

    // pending flags and remainder data
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_min   <= !i_command && sec_wrap;
            r_p_day   <= !i_command && hour_wrap;
            r_p_scr   <= !i_command && scr_hit;
            r_p_save  <= 1'b0;
            r_div_num <= min_inc;
            r_rem     <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[MinW-1:0], 1'b0};
            r_rem     <= rem_nx;
            if (o_stat.div_last) begin
                r_p_save <= rem_nx == '0;
            end
        end
    end

    // output beat registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_year_now      <= r_year;
            o_month_now     <= r_month;
            o_day_now       <= r_day;
            o_hour_now      <= r_hour;
            o_minute_now    <= r_min;
            o_second_now    <= r_sec;
            o_minute_rolled <= r_p_min;
            o_save_request  <= r_p_save;
            o_day_rolled    <= r_p_day;
            o_screen_off    <= r_p_scr;
            o_led_level     <= r_led;
        end
    end

endmodule

// ===== design/calendar_clock_with_screen_timeout_core.sv =====
// calendar clock with screen timeout: top level joining controller and datapath
// flow: a load or plain tick goes from idle to the hold state, which publishes it to the
//   output register once that is free; a tick that rolls the minute with a nonzero save
//   interval first passes the 7-step remainder unit; new beats are taken only in idle
// a new beat is taken while the previous result still waits in the output register
// reset: synchronous active low, clears control, time 00:00:00 on 1/1/2022, config defaults
module calendar_clock_with_screen_timeout_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccst_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [ccst_pkg::CfgW-1:0]        i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic                             i_display_on,
    input  logic [ccst_pkg::YearW-1:0]       i_load_year,
    input  logic [ccst_pkg::MonthW-1:0]      i_load_month,
    input  logic [ccst_pkg::DayW-1:0]        i_load_day,
    input  logic [ccst_pkg::HourW-1:0]       i_load_hour,
    input  logic [ccst_pkg::MinW-1:0]        i_load_minute,
    input  logic [ccst_pkg::SecW-1:0]        i_load_second,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ccst_pkg::YearW-1:0]       o_year_now,
    output logic [ccst_pkg::MonthW-1:0]      o_month_now,
    output logic [ccst_pkg::DayW-1:0]        o_day_now,
    output logic [ccst_pkg::HourW-1:0]       o_hour_now,
    output logic [ccst_pkg::MinW-1:0]        o_minute_now,
    output logic [ccst_pkg::SecW-1:0]        o_second_now,
    output logic                             o_minute_rolled,
    output logic                             o_save_request,
    output logic                             o_day_rolled,
    output logic                             o_screen_off,
    output logic                             o_led_level
);
    import ccst_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller
    ccst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready),
        .o_valid (o_valid)
    );

    // datapath
    ccst_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_display_on    (i_display_on),
        .i_load_year     (i_load_year),
        .i_load_month    (i_load_month),
        .i_load_day      (i_load_day),
        .i_load_hour     (i_load_hour),
        .i_load_minute   (i_load_minute),
        .i_load_second   (i_load_second),
        .o_year_now      (o_year_now),
        .o_month_now     (o_month_now),
        .o_day_now       (o_day_now),
        .o_hour_now      (o_hour_now),
        .o_minute_now    (o_minute_now),
        .o_second_now    (o_second_now),
        .o_minute_rolled (o_minute_rolled),
        .o_save_request  (o_save_request),
        .o_day_rolled    (o_day_rolled),
        .o_screen_off    (o_screen_off),
        .o_led_level     (o_led_level)
    );

endmodule

// ===== tb/tb_top.sv =====
// testbench for the calendar clock core: directed table, then random phases against a predictor
`timescale 1ns / 1ps

module tb_top;
    import ccst_pkg::*;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // register index with no register behind it
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned SettlePause    = 12;
    localparam int unsigned PhaseBeats     = 250;

    typedef struct packed {
        logic              command;
        logic              display_on;
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
    } t_clock_in;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
        logic              minute_rolled;
        logic              save_request;
        logic              day_rolled;
        logic              screen_off;
        logic              led_level;
    } t_clock_out;

    typedef struct packed {
        logic [TickW-1:0]  subtick;
        logic [SecW-1:0]   second;
        logic [MinW-1:0]   minute;
        logic [HourW-1:0]  hour;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [TickW-1:0]  countdown;
        logic              led;
    } t_calendar;

    typedef enum logic {
        ROW_BEAT,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_clock_in  beat;
        logic       typed;
        t_clock_out want;
        logic [7:0] tps;
        logic [7:0] save;
        logic [7:0] screen;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgW-1:0]     i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic                i_command;
    logic                i_display_on;
    logic [YearW-1:0]    i_load_year;
    logic [MonthW-1:0]   i_load_month;
    logic [DayW-1:0]     i_load_day;
    logic [HourW-1:0]    i_load_hour;
    logic [MinW-1:0]     i_load_minute;
    logic [SecW-1:0]     i_load_second;
    logic                o_valid;
    logic                i_ready;
    logic [YearW-1:0]    o_year_now;
    logic [MonthW-1:0]   o_month_now;
    logic [DayW-1:0]     o_day_now;
    logic [HourW-1:0]    o_hour_now;
    logic [MinW-1:0]     o_minute_now;
    logic [SecW-1:0]     o_second_now;
    logic                o_minute_rolled;
    logic                o_save_request;
    logic                o_day_rolled;
    logic                o_screen_off;
    logic                o_led_level;

    // predictor state and its copy of the registers
    t_calendar        cal;
    logic [TickW-1:0] cfg_tps;
    logic [IntW-1:0]  cfg_save;
    logic [TickW-1:0] cfg_screen;

    t_clock_out  pending_readings [$];
    t_dir_row    dir_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    bit          hold_off_req = 1'b0;

    calendar_clock_with_screen_timeout_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_display_on    (i_display_on),
        .i_load_year     (i_load_year),
        .i_load_month    (i_load_month),
        .i_load_day      (i_load_day),
        .i_load_hour     (i_load_hour),
        .i_load_minute   (i_load_minute),
        .i_load_second   (i_load_second),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_year_now      (o_year_now),
        .o_month_now     (o_month_now),
        .o_day_now       (o_day_now),
        .o_hour_now      (o_hour_now),
        .o_minute_now    (o_minute_now),
        .o_second_now    (o_second_now),
        .o_minute_rolled (o_minute_rolled),
        .o_save_request  (o_save_request),
        .o_day_rolled    (o_day_rolled),
        .o_screen_off    (o_screen_off),
        .o_led_level     (o_led_level)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // month length, 31 for any month code outside 1..12
    function automatic logic [DayW-1:0] month_days(
        input logic [MonthW-1:0] month,
        input logic [YearW-1:0]  year
    );
        logic [DayW-1:0] len;
        len = 5'd31;
        if (month >= 4'd1 && month <= 4'd12) begin
            len = (month == 4'd2 && year[1:0] == 2'b00) ? 5'd29 : MonthLen[month];
        end
        return len;
    endfunction

    function automatic void reset_calendar();
        cal         = '0;
        cal.day     = DayReset;
        cal.month   = MonthReset;
        cal.year    = YearReset;
        cfg_tps     = TpsReset;
        cfg_save    = SaveReset;
        cfg_screen  = ScreenReset;
    endfunction

    // one step of the calendar: load or tick, carries computed one bit wider than the counts
    function automatic t_clock_out advance_calendar(input t_clock_in beat);
        t_clock_out      r;
        logic [SecW:0]   sec_inc;
        logic [MinW:0]   min_inc;
        logic [HourW:0]  hour_inc;
        logic [DayW:0]   day_inc;
        logic [MonthW:0] mon_inc;
        logic [YearW:0]  year_inc;
        r = '0;
        if (beat.command == CMD_LOAD) begin
            cal.year   = beat.year;
            cal.month  = beat.month;
            cal.day    = beat.day;
            cal.hour   = beat.hour;
            cal.minute = beat.minute;
            cal.second = beat.second;
        end else begin
            cal.subtick = cal.subtick + 1'b1;
            if (cal.subtick >= cfg_tps) begin
                cal.subtick = '0;
                sec_inc = {1'b0, cal.second} + 7'd1;
                if (sec_inc >= SecPerMin) begin
                    cal.second = '0;
                    r.minute_rolled = 1'b1;
                    min_inc = {1'b0, cal.minute} + 7'd1;
                    if (cfg_save != 0 && (min_inc % cfg_save) == 0) begin
                        r.save_request = 1'b1;
                    end
                    if (min_inc >= MinPerHour) begin
                        cal.minute = '0;
                        hour_inc = {1'b0, cal.hour} + 6'd1;
                        if (hour_inc >= HourPerDay) begin
                            cal.hour = '0;
                            r.day_rolled = 1'b1;
                            day_inc = {1'b0, cal.day} + 6'd1;
                            if (day_inc > {1'b0, month_days(cal.month, cal.year)}) begin
                                cal.day = 5'd1;
                                mon_inc = {1'b0, cal.month} + 5'd1;
                                if (mon_inc > MonPerYear) begin
                                    cal.month = 4'd1;
                                    year_inc = {1'b0, cal.year} + 15'd1;
                                    cal.year = (year_inc > YearLimit) ? '0 : year_inc[YearW-1:0];
                                end else begin
                                    cal.month = mon_inc[MonthW-1:0];
                                end
                            end else begin
                                cal.day = day_inc[DayW-1:0];
                            end
                        end else begin
                            cal.hour = hour_inc[HourW-1:0];
                        end
                    end else begin
                        cal.minute = min_inc[MinW-1:0];
                    end
                end else begin
                    cal.second = sec_inc[SecW-1:0];
                end
            end
            // screen countdown moves only while lit, compared on every tick
            if (beat.display_on) begin
                cal.countdown = cal.countdown + 1'b1;
            end
            if (cal.countdown == cfg_screen) begin
                cal.countdown = '0;
                r.screen_off = 1'b1;
            end
            cal.led = ~cal.led;
        end
        r.year      = cal.year;
        r.month     = cal.month;
        r.day       = cal.day;
        r.hour      = cal.hour;
        r.minute    = cal.minute;
        r.second    = cal.second;
        r.led_level = cal.led;
        return r;
    endfunction

    // tick with noise on the ignored load fields
    function automatic t_clock_in tick_beat(input logic lit);
        t_clock_in   b;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        b = noise[$bits(t_clock_in)-1:0];
        b.command = CMD_TICK;
        b.display_on = lit;
        return b;
    endfunction

    function automatic t_clock_in load_beat(
        input logic lit, input int unsigned yr, input int unsigned mon, input int unsigned dy,
        input int unsigned hr, input int unsigned mi, input int unsigned se
    );
        t_clock_in b;
        b = '{CMD_LOAD, lit, yr[YearW-1:0], mon[MonthW-1:0], dy[DayW-1:0], hr[HourW-1:0],
              mi[MinW-1:0], se[SecW-1:0]};
        return b;
    endfunction

    function automatic t_dir_row beat_row(input t_clock_in b);
        return '{ROW_BEAT, b, 1'b0, '0, 8'd0, 8'd0, 8'd0};
    endfunction

    function automatic t_dir_row typed_row(input t_clock_in b, input t_clock_out want);
        return '{ROW_BEAT, b, 1'b1, want, 8'd0, 8'd0, 8'd0};
    endfunction

    function automatic t_dir_row config_row(
        input logic [7:0] tps, input logic [7:0] save, input logic [7:0] screen
    );
        return '{ROW_CONFIG, '0, 1'b0, '0, tps, save, screen};
    endfunction

    // random beat: mostly ticks, loads near a rollover, some legal dates, some raw bits
    function automatic t_clock_in random_beat(input int unsigned lit_pct);
        t_clock_in       b;
        int unsigned     pick;
        logic [DayW-1:0] mlen;
        logic [63:0]     noise;
        noise = {$urandom, $urandom};
        b = noise[$bits(t_clock_in)-1:0];
        pick = $urandom_range(0, 99);
        b.display_on = ($urandom_range(0, 99) < lit_pct);
        b.command = (pick < 80) ? CMD_TICK : CMD_LOAD;
        if (pick >= 80 && pick < 92) begin
            case ($urandom_range(0, 3))
                0:       b.year = 14'd9999;
                1:       b.year = YearW'(4 * $urandom_range(0, 2499));
                2:       b.year = YearReset;
                default: b.year = YearW'($urandom_range(0, 9999));
            endcase
            b.month  = ($urandom_range(0, 2) == 0) ? 4'd12 : MonthW'($urandom_range(1, 12));
            mlen     = month_days(b.month, b.year);
            b.day    = ($urandom_range(0, 1) != 0) ? mlen : DayW'($urandom_range(1, mlen));
            b.hour   = ($urandom_range(0, 1) != 0) ? 5'd23 : HourW'($urandom_range(0, 23));
            b.minute = ($urandom_range(0, 1) != 0) ? 6'd59 : MinW'($urandom_range(0, 59));
            b.second = SecW'($urandom_range(54, 59));
        end else if (pick >= 92 && pick < 97) begin
            b.year   = YearW'($urandom_range(0, 9999));
            b.month  = MonthW'($urandom_range(1, 12));
            b.day    = DayW'($urandom_range(1, month_days(b.month, b.year)));
            b.hour   = HourW'($urandom_range(0, 23));
            b.minute = MinW'($urandom_range(0, 59));
            b.second = SecW'($urandom_range(0, 59));
        end
        return b;
    endfunction

    // offer one beat in bursts with random gaps, predict it once accepted
    task automatic offer_beat(input t_clock_in beat, input logic typed, input t_clock_out want);
        int unsigned gap;
        t_clock_out  reading;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_command     <= beat.command;
        i_display_on  <= beat.display_on;
        i_load_year   <= beat.year;
        i_load_month  <= beat.month;
        i_load_day    <= beat.day;
        i_load_hour   <= beat.hour;
        i_load_minute <= beat.minute;
        i_load_second <= beat.second;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        reading = advance_calendar(beat);
        pending_readings.push_back(typed ? want : reading);
    endtask

    // block is idle once every reading is back, plus a margin for the remainder unit
    task automatic drain_readings();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SettlePause) @(posedge i_clk);
    endtask

    // write every register, then the unused index, which must change nothing
    task automatic set_config(
        input logic [7:0] tps, input logic [7:0] save, input logic [7:0] screen
    );
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgTicksPerSec;
        i_cfg_data  <= tps;
        @(posedge i_clk);
        i_cfg_index <= CfgSaveInt;
        i_cfg_data  <= save;
        @(posedge i_clk);
        i_cfg_index <= CfgScreenOn;
        i_cfg_data  <= screen;
        @(posedge i_clk);
        i_cfg_index <= CfgUnused;
        i_cfg_data  <= CfgW'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_tps    = tps;
        cfg_save   = save[IntW-1:0];
        cfg_screen = screen;
    endtask

    task automatic run_phase(
        input logic [7:0] tps, input logic [7:0] save, input logic [7:0] screen,
        input int unsigned lit_pct
    );
        drain_readings();
        set_config(tps, save, screen);
        repeat (PhaseBeats) offer_beat(random_beat(lit_pct), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: ready bursts, random ready, short stalls, toggling, and one long hold-off
    initial begin : ready_pattern
        int unsigned span;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            span = $urandom_range(4, 40);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_ready <= 1'b1;
                        repeat (span) @(posedge i_clk);
                    end
                    1: repeat (span) begin
                        i_ready <= 1'($urandom_range(0, 1));
                        @(posedge i_clk);
                    end
                    2: begin
                        i_ready <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge i_clk);
                    end
                    default: repeat (span) begin
                        i_ready <= ~i_ready;
                        @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // compare each result beat with the oldest predicted reading
    always @(posedge i_clk) begin : reading_check
        t_clock_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result beat with no reading expected, year %0d", $time,
                         o_year_now);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("year_now", want.year, o_year_now);
                check_field("month_now", want.month, o_month_now);
                check_field("day_now", want.day, o_day_now);
                check_field("hour_now", want.hour, o_hour_now);
                check_field("minute_now", want.minute, o_minute_now);
                check_field("second_now", want.second, o_second_now);
                check_field("minute_rolled", want.minute_rolled, o_minute_rolled);
                check_field("save_request", want.save_request, o_save_request);
                check_field("day_rolled", want.day_rolled, o_day_rolled);
                check_field("screen_off", want.screen_off, o_screen_off);
                check_field("led_level", want.led_level, o_led_level);
            end
        end
    end

    initial begin : stimulus
        // directed table, reset registers: two ticks per second, save every 10, screen 60
        dir_rows.push_back(typed_row(tick_beat(1'b0),
                           '{2022, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1}));
        dir_rows.push_back(typed_row(tick_beat(1'b0),
                           '{2022, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0}));
        dir_rows.push_back(typed_row(load_beat(1'b1, 9999, 12, 31, 23, 59, 59),
                           '{9999, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0}));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));
        // every count carries, year wraps to zero
        dir_rows.push_back(typed_row(tick_beat(1'b1),
                           '{0, 1, 1, 0, 0, 0, 1, 1, 1, 0, 0}));
        dir_rows.push_back(config_row(8'd1, 8'd1, 8'd3));
        // leap february, then a common year
        dir_rows.push_back(typed_row(load_beat(1'b0, 2024, 2, 28, 23, 59, 59),
                           '{2024, 2, 28, 23, 59, 59, 0, 0, 0, 0, 0}));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));
        dir_rows.push_back(beat_row(load_beat(1'b0, 2023, 2, 28, 23, 59, 59)));
        dir_rows.push_back(beat_row(tick_beat(1'b0)));
        // every field at its all-ones code, kept as loaded, wraps on the next tick
        dir_rows.push_back(typed_row(load_beat(1'b0, 16383, 15, 31, 31, 63, 63),
                           '{16383, 15, 31, 31, 63, 63, 0, 0, 0, 0, 0}));
        dir_rows.push_back(beat_row(tick_beat(1'b0)));
        // month code zero counts 31 days
        dir_rows.push_back(beat_row(load_beat(1'b0, 0, 0, 31, 23, 59, 59)));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));
        dir_rows.push_back(typed_row(load_beat(1'b1, 0, 0, 0, 0, 0, 0),
                           '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
        // zero registers: every tick is a second, no save, screen-off while dark
        dir_rows.push_back(config_row(8'd0, 8'd0, 8'd0));
        dir_rows.push_back(beat_row(tick_beat(1'b0)));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));
        dir_rows.push_back(beat_row(load_beat(1'b1, 2100, 13, 31, 23, 59, 59)));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));
        // save interval written with all data bits set keeps its low six bits
        dir_rows.push_back(config_row(8'd1, 8'hFF, 8'd255));
        dir_rows.push_back(beat_row(load_beat(1'b0, 2020, 6, 30, 10, 62, 59)));
        dir_rows.push_back(beat_row(tick_beat(1'b1)));

        reset_calendar();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CfgTicksPerSec;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_command     <= CMD_TICK;
        i_display_on  <= 1'b0;
        i_load_year   <= '0;
        i_load_month  <= '0;
        i_load_day    <= '0;
        i_load_hour   <= '0;
        i_load_minute <= '0;
        i_load_second <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CONFIG) begin
                drain_readings();
                set_config(dir_rows[r].tps, dir_rows[r].save, dir_rows[r].screen);
            end else begin
                offer_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // first random phase: the long hold-off starts while beats keep coming
        drain_readings();
        set_config(8'd1, 8'd1, 8'd1);
        hold_off_req = 1'b1;
        repeat (PhaseBeats) offer_beat(random_beat(50), 1'b0, '0);

        // more random phases over several register settings, the extremes among them
        run_phase(8'd0, 8'd0, 8'd0, 30);
        run_phase(8'd255, 8'd60, 8'd255, 95);
        run_phase(8'd2, 8'hFF, 8'($urandom_range(1, 255)), 70);
        run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 60)),
                  8'($urandom_range(1, 40)), 60);
        run_phase(8'd1, 8'd15, 8'd60, 90);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 50);
        run_phase(8'd3, 8'd10, 8'd2, 40);

        drain_readings();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin : run_limit
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ccst_pkg.sv
design/ccst_ctrl.sv
design/ccst_dp.sv
design/calendar_clock_with_screen_timeout_core.sv
tb/tb_top.sv
